@@ design/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared definitions of the script text tokenizer
// Constants, codes and types that the tokenizer modules share.
// ----------------------------------------------------------------------------
package stt_pkg;

    // sizes
    localparam int MAX_SPECIALS  = 8;
    localparam int LINE_BITS     = 16;
    localparam int LINE_OUT_W    = 16;
    localparam int SPECIAL_W     = 64;
    localparam int COUNT_W       = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_CHARS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPECIALS = 2'd2;

    // register reset values: the set {};,:|=/
    localparam logic [SPECIAL_W-1:0] SPECIAL_CHARS_RST = 64'd3404013482654006651;
    localparam logic [COUNT_W-1:0]   SPECIAL_COUNT_RST = 4'd8;

    // characters
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;

    // byte kinds
    localparam logic [2:0] KIND_SPACE   = 3'd0;
    localparam logic [2:0] KIND_COMMENT = 3'd1;
    localparam logic [2:0] KIND_WORD    = 3'd2;
    localparam logic [2:0] KIND_SPECIAL = 3'd3;
    localparam logic [2:0] KIND_QUOTE   = 3'd4;
    localparam logic [2:0] KIND_QUOTED  = 3'd5;

    // lexer modes
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_WORD    = 3'd1;
    localparam logic [2:0] MODE_RUN     = 3'd2;
    localparam logic [2:0] MODE_QUOTE   = 3'd3;
    localparam logic [2:0] MODE_LINEC   = 3'd4;
    localparam logic [2:0] MODE_BLOCKC  = 3'd5;

    typedef struct packed {
        logic [SPECIAL_W-1:0] special_chars;
        logic [COUNT_W-1:0]   special_count;
        logic                 full_specials;
    } cfg_t;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic [2:0]            byte_kind;
        logic                  token_begins;
        logic [LINE_OUT_W-1:0] line_number;
        logic                  last_out;
    } result_t;

endpackage

@@ design/stt_lexer.sv @@
// ----------------------------------------------------------------------------
// stt_lexer: lexer state and per-byte classification
// Classifies the staged byte against the lexer state and produces zero, one
// or two results; the state advances when the staged byte is consumed.
// ----------------------------------------------------------------------------
module stt_lexer (
    input  logic             clk,
    input  logic             rst_n,
    input  stt_pkg::cfg_t    cfg,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             advance,
    output stt_pkg::result_t res0,
    output stt_pkg::result_t res1,
    output logic [1:0]       res_count
);
    import stt_pkg::*;

    logic [2:0]           mode_reg, mode_next;
    logic                 held_reg, held_next;
    logic                 star_reg, star_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    logic       sp_b, sp_slash, is_ws;
    logic [2:0] mode_mid, slash_kind, slash_mode, kind;
    logic       begins, go_between, hold_now, comment_pair, slash_pre;
    logic [LINE_OUT_W-1:0] line_out;

    // match against the configured special set
    function automatic logic special_hit(input cfg_t c, input logic [7:0] b);
        logic [COUNT_W-1:0] n_eff;
        logic               hit;
        n_eff = (c.special_count > COUNT_W'(MAX_SPECIALS)) ?
                COUNT_W'(MAX_SPECIALS) : c.special_count;
        hit = 1'b0;
        for (int i = 0; i < MAX_SPECIALS; i++)
        begin
            if ((COUNT_W'(i) < n_eff) && (c.special_chars[8*i +: 8] == b))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    assign sp_b     = special_hit(cfg, in_byte);
    assign sp_slash = special_hit(cfg, CH_SLASH);
    assign is_ws    = (in_byte == CH_LF) || (in_byte == CH_CR) ||
                      (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    assign line_out = LINE_OUT_W'(line_reg);

    // a slash that turns out to be a token
    assign slash_kind = sp_slash ? KIND_SPECIAL : KIND_WORD;
    assign slash_mode = sp_slash ? (cfg.full_specials ? MODE_RUN : MODE_BETWEEN)
                                 : MODE_WORD;

    // classification and next state
    always_comb
    begin
        comment_pair = 1'b0;
        slash_pre    = 1'b0;
        mode_mid     = mode_reg;
        if (held_reg)
        begin
            if ((in_byte == CH_SLASH) || (in_byte == CH_STAR))
            begin
                comment_pair = 1'b1;
            end
            else
            begin
                slash_pre = 1'b1;
                mode_mid  = slash_mode;
            end
        end

        go_between = 1'b0;
        hold_now   = 1'b0;
        kind       = KIND_SPACE;
        begins     = 1'b0;
        mode_next  = mode_mid;
        star_next  = star_reg;
        case (mode_mid)
            MODE_WORD:
            begin
                if (is_ws || sp_b)
                    go_between = 1'b1;
                else
                    kind = KIND_WORD;
            end
            MODE_RUN:
            begin
                if (cfg.full_specials && sp_b)
                    kind = KIND_SPECIAL;
                else
                    go_between = 1'b1;
            end
            MODE_QUOTE:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    kind      = KIND_QUOTE;
                    mode_next = MODE_BETWEEN;
                end
                else
                begin
                    kind = KIND_QUOTED;
                end
            end
            MODE_LINEC:
            begin
                kind = KIND_COMMENT;
                if ((in_byte == CH_LF) || (in_byte == CH_CR))
                    mode_next = MODE_BETWEEN;
            end
            MODE_BLOCKC:
            begin
                kind = KIND_COMMENT;
                if (star_reg && (in_byte == CH_SLASH))
                begin
                    mode_next = MODE_BETWEEN;
                    star_next = 1'b0;
                end
                else
                begin
                    star_next = (in_byte == CH_STAR);
                end
            end
            default:
            begin
                go_between = 1'b1;
            end
        endcase

        // between tokens
        if (go_between)
        begin
            if (is_ws)
            begin
                kind      = KIND_SPACE;
                mode_next = MODE_BETWEEN;
            end
            else if (in_byte == CH_SLASH)
            begin
                if (!in_last)
                begin
                    hold_now = 1'b1;
                end
                else
                begin
                    begins    = 1'b1;
                    kind      = slash_kind;
                    mode_next = slash_mode;
                end
            end
            else
            begin
                begins = 1'b1;
                if (sp_b)
                begin
                    kind      = KIND_SPECIAL;
                    mode_next = cfg.full_specials ? MODE_RUN : MODE_BETWEEN;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    kind      = KIND_QUOTE;
                    mode_next = MODE_QUOTE;
                end
                else
                begin
                    kind      = KIND_WORD;
                    mode_next = MODE_WORD;
                end
            end
        end

        held_next = hold_now;
        line_next = line_reg;
        res0      = '{out_byte: in_byte, byte_kind: kind, token_begins: begins,
                      line_number: line_out, last_out: in_last};
        res1      = res0;
        if (comment_pair)
        begin
            res0 = '{out_byte: CH_SLASH, byte_kind: KIND_COMMENT, token_begins: 1'b0,
                     line_number: line_out, last_out: 1'b0};
            res1 = '{out_byte: in_byte, byte_kind: KIND_COMMENT, token_begins: 1'b0,
                     line_number: line_out, last_out: in_last};
            res_count = 2'd2;
            mode_next = (in_byte == CH_SLASH) ? MODE_LINEC : MODE_BLOCKC;
            star_next = 1'b0;
            held_next = 1'b0;
        end
        else
        begin
            if (slash_pre)
            begin
                res0 = '{out_byte: CH_SLASH, byte_kind: slash_kind, token_begins: 1'b1,
                         line_number: line_out, last_out: 1'b0};
                res1 = '{out_byte: in_byte, byte_kind: kind, token_begins: begins,
                         line_number: line_out, last_out: in_last};
                res_count = 2'd2;
            end
            else
            begin
                res_count = hold_now ? 2'd0 : 2'd1;
            end
            // line advances after the result of a line feed
            if (!hold_now && (in_byte == CH_LF) && (line_reg != {LINE_BITS{1'b1}}))
                line_next = line_reg + LINE_BITS'(1);
        end

        // end of text returns the lexer to its start state
        if (in_last)
        begin
            mode_next = MODE_BETWEEN;
            held_next = 1'b0;
            star_next = 1'b0;
            line_next = LINE_BITS'(1);
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BETWEEN;
            held_reg <= 1'b0;
            star_reg <= 1'b0;
            line_reg <= LINE_BITS'(1);
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            star_reg <= star_next;
            line_reg <= line_next;
        end
    end

endmodule

@@ design/stt_out_queue.sv @@
// ----------------------------------------------------------------------------
// stt_out_queue: result queue
// Small queue that takes up to two results per cycle and hands out one per
// output transaction.
// ----------------------------------------------------------------------------
module stt_out_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [1:0]               push_count,
    input  stt_pkg::result_t         push0,
    input  stt_pkg::result_t         push1,
    output logic                     room,
    output logic [stt_pkg::QCNT_W-1:0] count,
    output logic                     out_valid,
    input  logic                     out_stall,
    output stt_pkg::result_t         head
);
    import stt_pkg::*;

    result_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QCNT_W-1:0] n_in;
    logic              pop;

    assign n_in      = push ? QCNT_W'(push_count) : '0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign count     = count_reg;
    assign head      = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_in);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + n_in - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push && (push_count != 2'd0))
            mem[wr_ptr_reg] <= push0;
        if (push && (push_count == 2'd2))
            mem[wr_ptr_reg + QPTR_W'(1)] <= push1;
    end

endmodule

@@ design/script_text_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// script_text_tokenizer_unit: script text tokenizer
// Labels each byte of a script text and marks token starts and line numbers.
// ----------------------------------------------------------------------------
// One byte is taken per cycle into an input register unless in_stall is raised;
// the lexer classifies it from that register and writes its results into a
// four-entry result queue. A byte gives zero results (a held slash), one, or
// two (a held slash reported with the byte that decides it). Bytes flow at
// one per cycle as long as the queue has room for two results; the output side
// hands out one result per cycle while out_stall is low, so a stream of
// two-result bytes runs at the output rate of one result per cycle.
// Configuration writes are always ready and must only be issued while the
// block is idle.
module script_text_tokenizer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      text_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic [2:0]                      byte_kind,
    output logic                            token_begins,
    output logic [stt_pkg::LINE_OUT_W-1:0]  line_number,
    output logic                            last_out,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import stt_pkg::*;

    cfg_t              cfg_reg;
    logic              stage_valid_reg, stage_valid_next;
    logic [7:0]        stage_byte_reg;
    logic              stage_last_reg;
    logic              accept, advance, room;
    result_t           res0, res1, head;
    logic [1:0]        res_count;
    logic [QCNT_W-1:0] q_count;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.special_chars <= SPECIAL_CHARS_RST;
            cfg_reg.special_count <= SPECIAL_COUNT_RST;
            cfg_reg.full_specials <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SPECIAL_CHARS: cfg_reg.special_chars <= cfg_data[SPECIAL_W-1:0];
                CFG_SPECIAL_COUNT: cfg_reg.special_count <= cfg_data[COUNT_W-1:0];
                CFG_FULL_SPECIALS: cfg_reg.full_specials <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    assign advance  = stage_valid_reg && room;
    assign in_stall = stage_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= text_byte;
            stage_last_reg <= last_byte;
        end
    end

    // lexer
    stt_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_byte   (stage_byte_reg),
        .in_last   (stage_last_reg),
        .advance   (advance),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    // result queue
    stt_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (advance),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .count      (q_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head       (head)
    );

    assign out_byte     = head.out_byte;
    assign byte_kind    = head.byte_kind;
    assign token_begins = head.token_begins;
    assign line_number  = head.line_number;
    assign last_out     = head.last_out;

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (stage_valid_reg && !room))
        else $error("input stalled without a waiting byte");

    a_pair_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res_count == 2'd2)) |=> (q_count >= QCNT_W'(2)))
        else $error("two results not both queued");

    a_out_with_count: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == '0) |-> !out_valid)
        else $error("result offered from empty queue");

endmodule
